// ===== rtl/core/pipt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-in-polygon test: shared package
// Types and fixed constants of the block, some of them used by more than one file.
// ----------------------------------------------------------------------------
package pipt_pkg;

    // Width of one digit of the serial multiplier.
    localparam int unsigned DIGIT_W = 8;

    // Depth of the job queue between the front and the back.
    localparam int unsigned Q_DEPTH = 2;

    // Width of the result tdata: two flags padded to a byte.
    localparam int unsigned OUT_TDATA_W = 8;

    // Result of one polygon.
    typedef struct packed {
        logic on_boundary;
        logic inside_res;
    } res_t;

    // Status returned by the serial multiplier.
    typedef struct packed {
        logic done;
        logic neg;
    } mul_stat_t;

endpackage

// ===== rtl/core/pipt_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-in-polygon test: job queue
// Short first-in first-out queue that lets the front and the back stall
// independently of each other.
// ----------------------------------------------------------------------------
module pipt_fifo #(
    parameter int unsigned DATA_W = 258
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);

    localparam int unsigned PTR_W = (pipt_pkg::Q_DEPTH > 1) ? $clog2(pipt_pkg::Q_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(pipt_pkg::Q_DEPTH + 1);

    logic [DATA_W-1:0] mem [pipt_pkg::Q_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push, pop;

    assign in_ready  = (count_reg != CNT_W'(pipt_pkg::Q_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(pipt_pkg::Q_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(pipt_pkg::Q_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ===== rtl/core/pipt_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-in-polygon test: front
// Accepts vertex items, keeps the query point, the first and the previous
// vertex, and turns each item into a self-contained job for the back.
// ----------------------------------------------------------------------------
module pipt_front #(
    parameter int unsigned COORD_WIDTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [COORD_WIDTH-1:0]       point_x,
    input  logic [COORD_WIDTH-1:0]       point_y,
    input  logic [COORD_WIDTH-1:0]       vertex_x,
    input  logic [COORD_WIDTH-1:0]       vertex_y,
    input  logic                         first_vertex,
    input  logic                         last_vertex,
    output logic                         job_valid,
    input  logic                         job_ready,
    output logic [8*COORD_WIDTH+1:0]     job_data
);

    localparam int unsigned W = COORD_WIDTH;

    logic [W-1:0] query_x_reg, query_x_next;
    logic [W-1:0] query_y_reg, query_y_next;
    logic [W-1:0] start_x_reg, start_x_next;
    logic [W-1:0] start_y_reg, start_y_next;
    logic [W-1:0] prev_x_reg;
    logic [W-1:0] prev_y_reg;
    logic         accept;

    assign in_ready  = job_ready;
    assign job_valid = in_valid;
    assign accept    = in_valid && job_ready;

    // A first vertex samples the query point and becomes the closing target.
    assign query_x_next = first_vertex ? point_x  : query_x_reg;
    assign query_y_next = first_vertex ? point_y  : query_y_reg;
    assign start_x_next = first_vertex ? vertex_x : start_x_reg;
    assign start_y_next = first_vertex ? vertex_y : start_y_reg;

    // Job layout from the lowest bit: query x/y, previous x/y, vertex x/y,
    // start x/y, first flag, last flag.
    assign job_data = {last_vertex, first_vertex,
                       start_y_next, start_x_next,
                       vertex_y, vertex_x,
                       prev_y_reg, prev_x_reg,
                       query_y_next, query_x_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            query_x_reg <= '0;
            query_y_reg <= '0;
            start_x_reg <= '0;
            start_y_reg <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
        end else if (accept) begin
            query_x_reg <= query_x_next;
            query_y_reg <= query_y_next;
            start_x_reg <= start_x_next;
            start_y_reg <= start_y_next;
            prev_x_reg  <= vertex_x;
            prev_y_reg  <= vertex_y;
        end
    end

endmodule

// ===== rtl/core/pipt_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-in-polygon test: serial multiplier
// Exact signed product of two coordinate differences, one byte of the
// second operand per cycle, result as magnitude and sign.
// ----------------------------------------------------------------------------
module pipt_mul #(
    parameter int unsigned COORD_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic signed [COORD_WIDTH:0]   op_a,
    input  logic signed [COORD_WIDTH:0]   op_b,
    output pipt_pkg::mul_stat_t           stat,
    output logic [2*COORD_WIDTH-1:0]      mag
);

    localparam int unsigned W   = COORD_WIDTH;
    localparam int unsigned DW  = pipt_pkg::DIGIT_W;
    localparam int unsigned ND  = (W + DW - 1) / DW;
    localparam int unsigned MBW = ND * DW;
    localparam int unsigned AW  = W + MBW;
    localparam int unsigned CW  = $clog2(ND + 1);

    logic [W-1:0]   mag_a_reg;
    logic [MBW-1:0] mag_b_reg;
    logic [AW-1:0]  acc_reg;
    logic           neg_reg;
    logic [CW-1:0]  cnt_reg;
    logic           busy_reg;
    logic           done_reg;

    logic [W:0]     abs_a, abs_b;
    logic [DW-1:0]  digit;
    logic [W+DW-1:0] partial;
    logic [AW-1:0]  acc_next;

    // Differences of two coordinates never reach -2^W, so W bits hold |x|.
    assign abs_a    = op_a[W] ? (~op_a + 1'b1) : op_a;
    assign abs_b    = op_b[W] ? (~op_b + 1'b1) : op_b;
    assign digit    = mag_b_reg[MBW-1 -: DW];
    assign partial  = mag_a_reg * digit;
    assign acc_next = (acc_reg << DW) + AW'(partial);

    assign stat.done = done_reg;
    assign stat.neg  = neg_reg;
    assign mag       = acc_reg[2*W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(ND);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mag_a_reg <= abs_a[W-1:0];
            mag_b_reg <= MBW'(abs_b[W-1:0]);
            acc_reg   <= '0;
            neg_reg   <= op_a[W] ^ op_b[W];
        end else if (busy_reg) begin
            mag_b_reg <= mag_b_reg << DW;
            acc_reg   <= acc_next;
        end
    end

endmodule

// ===== rtl/core/pipt_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-in-polygon test: back
// Takes jobs from the queue, evaluates the edge into each job's vertex
// (none for a first vertex) and, for a last vertex, also the closing edge
// through the shared serial multiplier, keeps the parity and boundary flags,
// and holds the result of a closed polygon until it is taken.
module pipt_back #(
    parameter int unsigned COORD_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          job_valid,
    output logic                          job_ready,
    input  logic [8*COORD_WIDTH+1:0]      job_data,
    output logic                          mul_start,
    output logic signed [COORD_WIDTH:0]   mul_a,
    output logic signed [COORD_WIDTH:0]   mul_b,
    input  pipt_pkg::mul_stat_t           mul_stat,
    input  logic [2*COORD_WIDTH-1:0]      mul_mag,
    output logic                          out_valid,
    input  logic                          out_ready,
    output pipt_pkg::res_t                out_res
);

    localparam int unsigned W  = COORD_WIDTH;
    localparam int unsigned SW = 2 * W + 2;
    localparam int unsigned JW = 8 * W + 2;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_WAIT = 3'd2;
    localparam logic [2:0] S_EVAL = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    // Product order: cross product terms, then the dot product from the
    // first end, then the dot product from the second end.
    localparam logic [2:0] P_UX_WY = 3'd0;
    localparam logic [2:0] P_UY_WX = 3'd1;
    localparam logic [2:0] P_UX_WX = 3'd2;
    localparam logic [2:0] P_UY_WY = 3'd3;
    localparam logic [2:0] P_VX_ZX = 3'd4;
    localparam logic [2:0] P_VY_ZY = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [2:0]    pi_reg, pi_next;
    logic          phase_reg, phase_next;
    logic [JW-1:0] job_reg;
    logic          parity_reg, parity_next;
    logic          hit_reg, hit_next;
    logic          out_valid_reg, out_valid_next;
    pipt_pkg::res_t res_reg;
    logic [SW-1:0] sum_reg;
    logic          cross_zero_reg, cross_neg_reg, dot1_nn_reg;

    logic signed [W-1:0] px, py, ax, ay, bx, by;
    logic signed [W-1:0] jpx, jpy, jvx, jvy, jsx, jsy;
    logic signed [W:0]   ux, uy, wx, wy, vx, vy, zx, zy;
    logic                job_last, in_first, in_last;
    logic                pop, load_out;
    logic                eff_neg;
    logic [SW-1:0]       term, sum_base, sum_next;
    logic                degen, hit, fa, fb, straddle, crs, toggle;

    assign px        = job_reg[0*W +: W];
    assign py        = job_reg[1*W +: W];
    assign jpx       = job_reg[2*W +: W];
    assign jpy       = job_reg[3*W +: W];
    assign jvx       = job_reg[4*W +: W];
    assign jvy       = job_reg[5*W +: W];
    assign jsx       = job_reg[6*W +: W];
    assign jsy       = job_reg[7*W +: W];
    assign job_last  = job_reg[8*W+1];
    assign in_first  = job_data[8*W];
    assign in_last   = job_data[8*W+1];

    // In the closing phase the edge runs from the job's vertex back to the first vertex.
    assign ax = phase_reg ? jvx : jpx;
    assign ay = phase_reg ? jvy : jpy;
    assign bx = phase_reg ? jsx : jvx;
    assign by = phase_reg ? jsy : jvy;

    assign ux = {px[W-1], px} - {ax[W-1], ax};
    assign uy = {py[W-1], py} - {ay[W-1], ay};
    assign wx = {bx[W-1], bx} - {ax[W-1], ax};
    assign wy = {by[W-1], by} - {ay[W-1], ay};
    assign vx = {px[W-1], px} - {bx[W-1], bx};
    assign vy = {py[W-1], py} - {by[W-1], by};
    assign zx = {ax[W-1], ax} - {bx[W-1], bx};
    assign zy = {ay[W-1], ay} - {by[W-1], by};

    always_comb begin
        case (pi_reg)
            P_UX_WY: begin mul_a = ux; mul_b = wy; end
            P_UY_WX: begin mul_a = uy; mul_b = wx; end
            P_UX_WX: begin mul_a = ux; mul_b = wx; end
            P_UY_WY: begin mul_a = uy; mul_b = wy; end
            P_VX_ZX: begin mul_a = vx; mul_b = zx; end
            P_VY_ZY: begin mul_a = vy; mul_b = zy; end
            default: begin mul_a = ux; mul_b = wy; end
        endcase
    end

    // Even products start a new sum; the second cross term is subtracted.
    assign eff_neg  = mul_stat.neg ^ (pi_reg == P_UY_WX);
    assign term     = SW'(mul_mag) ^ {SW{eff_neg}};
    assign sum_base = pi_reg[0] ? sum_reg : '0;
    assign sum_next = sum_base + term + SW'(eff_neg);

    // Edge evaluation once all six products are in.
    assign degen    = (ax == bx) && (ay == by);
    assign hit      = degen ? ((px == ax) && (py == ay))
                            : (cross_zero_reg && dot1_nn_reg && !sum_reg[SW-1]);
    assign fa       = (ay == py) && !(ax < px);
    assign fb       = (by == py) && !(bx < px);
    assign straddle = !(((ay > py) && (by > py)) || ((ay < py) && (by < py)));
    assign crs      = !cross_zero_reg && ((cross_neg_reg && (by > ay)) ||
                                          (!cross_neg_reg && (by < ay)));

    always_comb begin
        if (fa && fb) begin
            toggle = 1'b0;
        end else if (fa) begin
            toggle = (by < ay);
        end else if (fb) begin
            toggle = (ay < by);
        end else begin
            toggle = straddle && crs;
        end
    end

    assign pop       = (state_reg == S_IDLE) && job_valid;
    assign job_ready = (state_reg == S_IDLE);
    assign mul_start = (state_reg == S_MUL);
    assign load_out  = (state_reg == S_OUT) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

    always_comb begin
        state_next     = state_reg;
        pi_next        = pi_reg;
        phase_next     = phase_reg;
        parity_next    = parity_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE: begin
                if (pop) begin
                    pi_next = P_UX_WY;
                    if (in_first) begin
                        parity_next = 1'b0;
                        hit_next    = 1'b0;
                    end
                    if (!in_first) begin
                        phase_next = 1'b0;
                        state_next = S_MUL;
                    end else if (in_last) begin
                        phase_next = 1'b1;
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL: begin
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (mul_stat.done) begin
                    if (pi_reg == P_VY_ZY) begin
                        state_next = S_EVAL;
                    end else begin
                        pi_next    = pi_reg + 1'b1;
                        state_next = S_MUL;
                    end
                end
            end
            S_EVAL: begin
                hit_next    = hit_reg || hit;
                parity_next = parity_reg ^ toggle;
                if (!phase_reg && job_last) begin
                    phase_next = 1'b1;
                    pi_next    = P_UX_WY;
                    state_next = S_MUL;
                end else if (job_last) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_OUT: begin
                if (load_out) begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            pi_reg        <= P_UX_WY;
            phase_reg     <= 1'b0;
            parity_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pi_reg        <= pi_next;
            phase_reg     <= phase_next;
            parity_reg    <= parity_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            job_reg <= job_data;
        end
        if ((state_reg == S_WAIT) && mul_stat.done) begin
            // Record each finished sum before the next pair overwrites it.
            if (pi_reg == P_UX_WX) begin
                cross_zero_reg <= (sum_reg == '0);
                cross_neg_reg  <= sum_reg[SW-1];
            end
            if (pi_reg == P_VX_ZX) begin
                dot1_nn_reg <= !sum_reg[SW-1];
            end
            sum_reg <= sum_next;
        end
        if (load_out) begin
            res_reg.inside_res  <= hit_reg || parity_reg;
            res_reg.on_boundary <= hit_reg;
        end
    end

endmodule

// ===== rtl/core/point_in_polygon_test_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-in-polygon test: top level
// Ray-casting point-in-polygon test with an exact boundary check over a
// stream of polygon vertices.
// ----------------------------------------------------------------------------
//  Channel  Direction  tdata (low bit up)                       tuser / tlast
//  s_       in         point_x, point_y, vertex_x, vertex_y     first_vertex / last_vertex
//  m_       out        inside_res, on_boundary, zero padding    - / -
//
//  Each edge takes six products from the shared byte-serial multiplier, each over ND =
//  ceil(COORD_WIDTH / 8) bytes. A first item evaluates no edge, a later item the edge
//  from the previous vertex, a last item that edge and the closing edge, a first and
//  last item only the closing edge. A two-entry queue lets the input take items while
//  the back is busy; a held result stalls the back only when the next one is due. Reset
//  is synchronous, active low, and clears the front's coordinates, not the queued jobs.
// ----------------------------------------------------------------------------
module point_in_polygon_test_top #(
    parameter int unsigned COORD_WIDTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // point_x, point_y, vertex_x, vertex_y, zero padding to whole bytes
    input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]    s_tdata,
    // first_vertex
    input  logic                                  s_tuser,
    input  logic                                  s_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // inside_res, on_boundary, zero padding
    output logic [pipt_pkg::OUT_TDATA_W-1:0]      m_tdata
);

    localparam int unsigned W  = COORD_WIDTH;
    localparam int unsigned JW = 8 * W + 2;

    logic [W-1:0]          point_x, point_y, vertex_x, vertex_y;
    logic                  job_in_valid, job_in_ready;
    logic [JW-1:0]         job_in_data;
    logic                  job_out_valid, job_out_ready;
    logic [JW-1:0]         job_out_data;
    logic                  mul_start;
    logic signed [W:0]     mul_a, mul_b;
    pipt_pkg::mul_stat_t   mul_stat;
    logic [2*W-1:0]        mul_mag;
    pipt_pkg::res_t        res;

    assign point_x  = s_tdata[0*W +: W];
    assign point_y  = s_tdata[1*W +: W];
    assign vertex_x = s_tdata[2*W +: W];
    assign vertex_y = s_tdata[3*W +: W];

    assign m_tdata = {{(pipt_pkg::OUT_TDATA_W - 2){1'b0}}, res.on_boundary, res.inside_res};

    pipt_front #(
        .COORD_WIDTH(W)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .point_x     (point_x),
        .point_y     (point_y),
        .vertex_x    (vertex_x),
        .vertex_y    (vertex_y),
        .first_vertex(s_tuser),
        .last_vertex (s_tlast),
        .job_valid   (job_in_valid),
        .job_ready   (job_in_ready),
        .job_data    (job_in_data)
    );

    pipt_fifo #(
        .DATA_W(JW)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (job_in_valid),
        .in_ready (job_in_ready),
        .in_data  (job_in_data),
        .out_valid(job_out_valid),
        .out_ready(job_out_ready),
        .out_data (job_out_data)
    );

    pipt_mul #(
        .COORD_WIDTH(W)
    ) u_mul (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (mul_start),
        .op_a   (mul_a),
        .op_b   (mul_b),
        .stat   (mul_stat),
        .mag    (mul_mag)
    );

    pipt_back #(
        .COORD_WIDTH(W)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .job_valid(job_out_valid),
        .job_ready(job_out_ready),
        .job_data (job_out_data),
        .mul_start(mul_start),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .mul_stat (mul_stat),
        .mul_mag  (mul_mag),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_res  (res)
    );

endmodule

// ===== rtl/core/pipt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-in-polygon test: port checker
// Checks what the top level shows on its ports over time.
// ----------------------------------------------------------------------------
module pipt_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [pipt_pkg::OUT_TDATA_W-1:0] m_tdata
);

    // No result survives a reset.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // The queue is empty after a reset, so the input is ready.
    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready after reset");

    // A stalled result keeps its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // A point on the boundary always counts as inside.
    a_boundary_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> m_tdata[0])
        else $error("boundary point reported outside");

    // Padding bits of a result stay clear.
    a_padding: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[pipt_pkg::OUT_TDATA_W-1:2] == '0))
        else $error("result padding not zero");

endmodule

bind point_in_polygon_test_top pipt_checker u_pipt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

// ===== test/point_in_polygon_test_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-in-polygon test: testbench
// Streams polygons as vertex items into the block and checks every verdict
// against an exact inside/boundary predictor kept in the bench. A short
// directed set covers orphan vertices, ray corner cases, extreme coordinates
// and single-vertex polygons. Random polygons follow, with random gaps and
// back-pressure, and a final stretch runs without any idling.
// ----------------------------------------------------------------------------
module point_in_polygon_test_top_tb;

    localparam int unsigned COORD_W   = 32;
    localparam int unsigned S_TDATA_W = ((4*COORD_W+7)/8)*8;
    localparam int unsigned N_ITEMS   = 1650;
    localparam int unsigned N_RELAXED = 1450;

    localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;
    localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7fff_ffff;

    // Coordinate generation styles.
    typedef enum int {
        SPREAD_TINY,
        SPREAD_FULL,
        SPREAD_EXTREME,
        SPREAD_COARSE
    } spread_t;

    typedef logic signed [COORD_W-1:0] coord_t;
    // Wide enough for exact cross and dot products of coordinate differences.
    typedef logic signed [71:0] wide_t;

    logic                             aclk = 1'b0;
    logic                             aresetn;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [S_TDATA_W-1:0]             s_tdata;
    logic                             s_tuser;
    logic                             s_tlast;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [pipt_pkg::OUT_TDATA_W-1:0] m_tdata;

    point_in_polygon_test_top #(
        .COORD_WIDTH(COORD_W)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Predictor state.
    wide_t held_x, held_y;
    wide_t origin_x, origin_y;
    wide_t trail_x, trail_y;
    logic  ray_parity;
    logic  on_edge_seen;

    pipt_pkg::res_t expected_verdicts[$];
    pipt_pkg::res_t head_verdict;
    int unsigned    mismatch_count;
    int unsigned    items_sent;
    bit             gaps_on;
    bit             stalls_on;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    function automatic int sgn(input wide_t v);
        return (v == 0) ? 0 : ((v < 0) ? -1 : 1);
    endfunction

    // One edge from a to b: boundary containment and ray crossing.
    function automatic void trace_edge(input wide_t ax, input wide_t ay,
                                       input wide_t bx, input wide_t by);
        wide_t cr, d1, d2;
        logic  hit, fa, fb;
        int    sa, sb, c;
        if (ax == bx && ay == by) begin
            hit = (held_x == ax) && (held_y == ay);
        end else begin
            cr  = (held_x - ax) * (by - ay) - (held_y - ay) * (bx - ax);
            d1  = (held_x - ax) * (bx - ax) + (held_y - ay) * (by - ay);
            d2  = (held_x - bx) * (ax - bx) + (held_y - by) * (ay - by);
            hit = (cr == 0) && (d1 >= 0) && (d2 >= 0);
        end
        if (hit) begin
            on_edge_seen = 1'b1;
        end
        // An end lying on the ray counts only when the other end is below it.
        fa = (ay == held_y) && (ax >= held_x);
        fb = (by == held_y) && (bx >= held_x);
        if (fa && fb) begin
            return;
        end else if (fa) begin
            if (by < ay) ray_parity = ~ray_parity;
        end else if (fb) begin
            if (ay < by) ray_parity = ~ray_parity;
        end else begin
            sa = sgn(ay - held_y);
            sb = sgn(by - held_y);
            if (sa * sb <= 0) begin
                c = sgn((ax - held_x) * (by - ay) - (ay - held_y) * (bx - ax));
                if (c * sgn(by - ay) > 0) ray_parity = ~ray_parity;
            end
        end
    endfunction

    function automatic void advance_polygon(input coord_t px, input coord_t py,
                                            input coord_t vx, input coord_t vy,
                                            input bit is_first, input bit is_last);
        wide_t          wx, wy;
        pipt_pkg::res_t verdict;
        wx = vx;
        wy = vy;
        if (is_first) begin
            held_x       = px;
            held_y       = py;
            origin_x     = wx;
            origin_y     = wy;
            ray_parity   = 1'b0;
            on_edge_seen = 1'b0;
        end else begin
            trace_edge(trail_x, trail_y, wx, wy);
        end
        trail_x = wx;
        trail_y = wy;
        if (is_last) begin
            trace_edge(wx, wy, origin_x, origin_y);
            verdict.on_boundary = on_edge_seen;
            verdict.inside_res  = on_edge_seen | ray_parity;
            expected_verdicts = {expected_verdicts, verdict};
        end
    endfunction

    // Called at a rising edge; returns at the edge where the item is taken, or after a random idle gap that follows it.
    task automatic send_vertex(input coord_t px, input coord_t py,
                               input coord_t vx, input coord_t vy,
                               input bit is_first, input bit is_last);
        s_tvalid <= 1'b1;
        s_tdata  <= {vy, vx, py, px};
        s_tuser  <= is_first;
        s_tlast  <= is_last;
        do @(posedge aclk); while (!s_tready);
        advance_polygon(px, py, vx, vy, is_first, is_last);
        items_sent++;
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
    endtask

    function automatic coord_t rand_coord(input spread_t spread);
        case (spread)
            SPREAD_TINY:    return coord_t'(int'($urandom_range(0, 20)) - 10);
            SPREAD_FULL:    return coord_t'($urandom);
            SPREAD_EXTREME: begin
                case ($urandom_range(0, 5))
                    0:       return C_MIN;
                    1:       return C_MAX;
                    2:       return coord_t'(0);
                    3:       return coord_t'(-1);
                    4:       return C_MIN + 1;
                    default: return C_MAX - 1;
                endcase
            end
            // Coarse grid of large values, so collinear points are common.
            default:        return coord_t'((int'($urandom_range(0, 15)) - 8) * 32'sh1000_0000);
        endcase
    endfunction

    function automatic coord_t midpoint(input coord_t a, input coord_t b);
        wide_t s;
        s = wide_t'(a) + wide_t'(b);
        return coord_t'(s >>> 1);
    endfunction

    // Receiver back-pressure in random bursts.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (stalls_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_verdicts.size() == 0) begin
                report_mismatch($sformatf("verdict %b with none outstanding", m_tdata));
            end else begin
                head_verdict = expected_verdicts.pop_front();
                if (m_tdata[0] !== head_verdict.inside_res ||
                    m_tdata[1] !== head_verdict.on_boundary ||
                    m_tdata[pipt_pkg::OUT_TDATA_W-1:2] !== '0) begin
                    report_mismatch($sformatf(
                        "inside %b/%b boundary %b/%b padding %b (got/want)",
                        m_tdata[0], head_verdict.inside_res,
                        m_tdata[1], head_verdict.on_boundary,
                        m_tdata[pipt_pkg::OUT_TDATA_W-1:2]));
                end
            end
        end
    end

    // Must run straight after reset: the chain starts from the cleared state.
    task automatic test_orphan_vertices();
        send_vertex(coord_t'(99), coord_t'(-99), coord_t'(3), coord_t'(4), 1'b0, 1'b0);
        send_vertex(coord_t'(1), coord_t'(1), coord_t'(5), coord_t'(-2), 1'b0, 1'b1);
        // The chain carries on after a last without a new first.
        send_vertex(coord_t'(0), coord_t'(0), coord_t'(-4), coord_t'(6), 1'b0, 1'b1);
    endtask

    task automatic test_ray_cases();
        // Plain inside point.
        send_vertex(coord_t'(5), coord_t'(5), coord_t'(0), coord_t'(0), 1'b1, 1'b0);
        send_vertex(coord_t'(0), coord_t'(0), coord_t'(10), coord_t'(0), 1'b0, 1'b0);
        send_vertex(coord_t'(0), coord_t'(0), coord_t'(10), coord_t'(10), 1'b0, 1'b0);
        send_vertex(coord_t'(0), coord_t'(0), coord_t'(0), coord_t'(10), 1'b0, 1'b1);
        // Ray running along a horizontal edge.
        send_vertex(coord_t'(-5), coord_t'(0), coord_t'(0), coord_t'(0), 1'b1, 1'b0);
        send_vertex(coord_t'(0), coord_t'(0), coord_t'(10), coord_t'(0), 1'b0, 1'b0);
        send_vertex(coord_t'(0), coord_t'(0), coord_t'(10), coord_t'(10), 1'b0, 1'b0);
        send_vertex(coord_t'(0), coord_t'(0), coord_t'(0), coord_t'(10), 1'b0, 1'b1);
        // Ray through a vertex with one neighbour above and one below.
        send_vertex(coord_t'(-5), coord_t'(5), coord_t'(0), coord_t'(0), 1'b1, 1'b0);
        send_vertex(coord_t'(0), coord_t'(0), coord_t'(10), coord_t'(5), 1'b0, 1'b0);
        send_vertex(coord_t'(0), coord_t'(0), coord_t'(0), coord_t'(10), 1'b0, 1'b1);
    endtask

    task automatic test_extreme_coordinates();
        send_vertex(coord_t'(0), C_MIN, C_MIN, C_MIN, 1'b1, 1'b0);
        send_vertex(C_MAX, C_MAX, C_MAX, C_MIN, 1'b0, 1'b0);
        send_vertex(C_MIN, C_MIN, C_MAX, C_MAX, 1'b0, 1'b1);
        send_vertex(C_MIN, C_MAX, C_MAX, C_MAX, 1'b1, 1'b0);
        send_vertex(coord_t'(-1), coord_t'(-1), C_MIN, C_MAX, 1'b0, 1'b0);
        send_vertex(coord_t'(0), coord_t'(0), C_MIN, C_MIN, 1'b0, 1'b1);
    endtask

    task automatic test_single_vertex();
        send_vertex(coord_t'(7), coord_t'(-7), coord_t'(7), coord_t'(-7), 1'b1, 1'b1);
        send_vertex(coord_t'(8), coord_t'(-7), coord_t'(7), coord_t'(-7), 1'b1, 1'b1);
    endtask

    task automatic test_random_polygons(input int unsigned item_goal, input bit allow_idle);
        coord_t      poly_x[8], poly_y[8];
        coord_t      qx, qy;
        spread_t     spread;
        int unsigned n, k, j;
        while (items_sent < item_goal) begin
            gaps_on   = allow_idle && ($urandom_range(0, 3) != 0);
            stalls_on = allow_idle && ($urandom_range(0, 3) != 0);
            spread    = spread_t'($urandom_range(0, 3));
            if ($urandom_range(0, 9) == 0) begin
                // Loose items with arbitrary framing flags.
                repeat ($urandom_range(1, 3)) begin
                    send_vertex(rand_coord(spread), rand_coord(spread),
                                rand_coord(spread), rand_coord(spread),
                                1'($urandom), 1'($urandom));
                end
            end else begin
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
                for (j = 0; j < n; j++) begin
                    if (j > 0 && $urandom_range(0, 7) == 0) begin
                        poly_x[j] = poly_x[j-1];
                        poly_y[j] = poly_y[j-1];
                    end else begin
                        poly_x[j] = rand_coord(spread);
                        poly_y[j] = rand_coord(spread);
                    end
                end
                k = $urandom_range(0, n - 1);
                case ($urandom_range(0, 3))
                    0: begin
                        qx = rand_coord(spread);
                        qy = rand_coord(spread);
                    end
                    1: begin
                        qx = poly_x[k];
                        qy = poly_y[k];
                    end
                    2: begin
                        qx = midpoint(poly_x[k], poly_x[(k + 1) % n]);
                        qy = midpoint(poly_y[k], poly_y[(k + 1) % n]);
                    end
                    default: begin
                        qx = rand_coord(spread);
                        qy = poly_y[k];
                    end
                endcase
                send_vertex(qx, qy, poly_x[0], poly_y[0], 1'b1, n == 1);
                for (j = 1; j < n; j++) begin
                    // The point fields are ignored here, so they carry noise.
                    send_vertex(coord_t'($urandom), coord_t'($urandom),
                                poly_x[j], poly_y[j], 1'b0, j == n - 1);
                end
            end
        end
    endtask

    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        aresetn        <= 1'b0;
        s_tvalid       <= 1'b0;
        s_tdata        <= '0;
        s_tuser        <= 1'b0;
        s_tlast        <= 1'b0;
        held_x          = '0;
        held_y          = '0;
        origin_x        = '0;
        origin_y        = '0;
        trail_x         = '0;
        trail_y         = '0;
        ray_parity      = 1'b0;
        on_edge_seen    = 1'b0;
        mismatch_count  = 0;
        items_sent      = 0;
        gaps_on         = 1'b1;
        stalls_on       = 1'b1;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        test_orphan_vertices();
        test_ray_cases();
        test_extreme_coordinates();
        test_single_vertex();
        test_random_polygons(N_RELAXED, 1'b1);
        test_random_polygons(N_ITEMS, 1'b0);

        s_tvalid <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge aclk);
        // Room for a stray verdict to show up after the last expected one.
        repeat (200) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
